// ===== sv/nearest_rating_pair_matcher_unit_assert.svh =====
// Assertion macros for the rating pair matcher.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef NEAREST_RATING_PAIR_MATCHER_UNIT_ASSERT_SVH
`define NEAREST_RATING_PAIR_MATCHER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define NRPM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nrpm: same-cycle check failed");
`define NRPM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nrpm: next-cycle check failed");
`else
`define NRPM_ASSERT_IMP(name, ante, cons)
`define NRPM_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ===== sv/nrpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nrpm_pkg;

  localparam int unsigned PID_W    = 16;
  localparam int unsigned RATING_W = 16;
  localparam int unsigned GAME_W   = 8;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [THR_W-1:0] THR_RESET = 16'd100;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_THR = 1'b1;

  // Operation codes carried on the input side
  localparam logic FUNC_REQUEST  = 1'b0;
  localparam logic FUNC_WITHDRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_QUEUED    = 3'd0,
    ST_MATCHED   = 3'd1,
    ST_WITHDRAWN = 3'd2,
    ST_ALREADY   = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  // One word of the waiting table
  typedef struct packed {
    logic                valid;
    logic [PID_W-1:0]    player;
    logic [RATING_W-1:0] rating;
    logic [GAME_W-1:0]   game;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/nrpm_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single-port-write, single-port-read table memory with a registered read.
module nrpm_table
  import nrpm_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/nearest_rating_pair_matcher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each item passes through the states idle, one sweep of the table through its
// single read port, drain and decision; a new item is taken only back in idle.
// A stalled result holds the block in its decision step until it is taken.
// Reset (rst_n, synchronous, active low) starts a clearing pass over the
// table; no item is taken until it ends, configuration writes are taken in every state.
`include "nearest_rating_pair_matcher_unit_assert.svh"

module nearest_rating_pair_matcher_unit
  import nrpm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [39:0]          in_tdata,   // player_id[15:0], rating[31:16], game_id[39:32]
  input  wire logic [0:0]           in_tuser,   // func[0]
  // result channel
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [15:0]               out_tdata,  // partner_id[15:0]
  output logic [2:0]                out_tuser,  // status[2:0]
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]     cfg_data
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  // The sequencer walks through the states below once per item. After reset it
  // first sweeps the table, writing every word as invalid.
  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_DECIDE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;

  // Read pipeline: the memory returns the word in the cycle after its address.
  logic          rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  entry_t        rd_data;

  // Latched request
  logic                req_func_r, req_func_nxt;
  logic [PID_W-1:0]    req_pid_r, req_pid_nxt;
  logic [RATING_W-1:0] req_rating_r, req_rating_nxt;
  logic [GAME_W-1:0]   req_game_r, req_game_nxt;

  // Candidates gathered during the sweep
  logic                dup_found_r, dup_found_nxt;
  logic [AW-1:0]       dup_idx_r, dup_idx_nxt;
  logic                free_found_r, free_found_nxt;
  logic [AW-1:0]       free_idx_r, free_idx_nxt;
  logic                eq_found_r, eq_found_nxt;
  logic [AW-1:0]       eq_idx_r, eq_idx_nxt;
  logic [PID_W-1:0]    eq_player_r, eq_player_nxt;
  logic                lo_found_r, lo_found_nxt;
  logic [AW-1:0]       lo_idx_r, lo_idx_nxt;
  logic [RATING_W-1:0] lo_rating_r, lo_rating_nxt;
  logic [PID_W-1:0]    lo_player_r, lo_player_nxt;
  logic                hi_found_r, hi_found_nxt;
  logic [AW-1:0]       hi_idx_r, hi_idx_nxt;
  logic [RATING_W-1:0] hi_rating_r, hi_rating_nxt;
  logic [PID_W-1:0]    hi_player_r, hi_player_nxt;

  // Thresholds
  logic [THR_W-1:0] lo_thr_r, lo_thr_nxt;
  logic [THR_W-1:0] hi_thr_r, hi_thr_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [PID_W-1:0] out_partner_r, out_partner_nxt;

  // Memory write port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;

  logic in_fire;
  logic dec_fire;

  // Sweep comparisons
  logic same_game;
  logic dup_hit, free_hit, eq_hit, lo_hit, hi_hit;

  // Decision
  logic [RATING_W-1:0] lo_gap, hi_gap;
  logic                lo_ok, hi_ok;
  logic                dec_we;
  logic [AW-1:0]       dec_addr;
  entry_t              dec_data;
  status_t             dec_status;
  logic [PID_W-1:0]    dec_partner;

  nrpm_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign dec_fire   = (state_r == S_DECIDE) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_partner_r;
  assign out_tuser  = out_status_r;

  // Each swept word is compared against the latched request. The table is
  // swept from index 0 upwards, so the first hit on a tie is the lowest slot,
  // and only a strictly better candidate replaces an earlier one. Among
  // equal ratings the lowest player id wins; below the request the highest
  // rating and then the highest player id win, above it the lowest of both.
  always_comb begin
    same_game = rd_vld_r && rd_data.valid && (rd_data.game == req_game_r);
    dup_hit   = rd_vld_r && rd_data.valid && (rd_data.player == req_pid_r) && !dup_found_r;
    free_hit  = rd_vld_r && !rd_data.valid && !free_found_r;
    eq_hit    = same_game && (rd_data.rating == req_rating_r) &&
                (!eq_found_r || (rd_data.player < eq_player_r));
    lo_hit    = same_game && (rd_data.rating < req_rating_r) &&
                (!lo_found_r || (rd_data.rating > lo_rating_r) ||
                 ((rd_data.rating == lo_rating_r) && (rd_data.player > lo_player_r)));
    hi_hit    = same_game && (rd_data.rating > req_rating_r) &&
                (!hi_found_r || (rd_data.rating < hi_rating_r) ||
                 ((rd_data.rating == hi_rating_r) && (rd_data.player < hi_player_r)));
  end

  // The final choice. Gaps cannot wrap, because the lower candidate lies
  // strictly below the request and the upper one strictly above it.
  always_comb begin
    lo_gap      = req_rating_r - lo_rating_r;
    hi_gap      = hi_rating_r - req_rating_r;
    lo_ok       = lo_found_r && (lo_gap <= lo_thr_r);
    hi_ok       = hi_found_r && (hi_gap <= hi_thr_r);
    dec_we      = 1'b0;
    dec_addr    = dup_idx_r;
    dec_data    = '0;
    dec_status  = ST_ABSENT;
    dec_partner = '0;
    if (req_func_r == FUNC_WITHDRAW) begin
      if (dup_found_r) begin
        dec_we     = 1'b1;
        dec_addr   = dup_idx_r;
        dec_status = ST_WITHDRAWN;
      end else begin
        dec_status = ST_ABSENT;
      end
    end else if (dup_found_r) begin
      dec_status = ST_ALREADY;
    end else if (eq_found_r) begin
      dec_we      = 1'b1;
      dec_addr    = eq_idx_r;
      dec_status  = ST_MATCHED;
      dec_partner = eq_player_r;
    end else if (hi_ok && (!lo_ok || (hi_gap < lo_gap))) begin
      dec_we      = 1'b1;
      dec_addr    = hi_idx_r;
      dec_status  = ST_MATCHED;
      dec_partner = hi_player_r;
    end else if (lo_ok) begin
      dec_we      = 1'b1;
      dec_addr    = lo_idx_r;
      dec_status  = ST_MATCHED;
      dec_partner = lo_player_r;
    end else if (free_found_r) begin
      dec_we          = 1'b1;
      dec_addr        = free_idx_r;
      dec_data.valid  = 1'b1;
      dec_data.player = req_pid_r;
      dec_data.rating = req_rating_r;
      dec_data.game   = req_game_r;
      dec_status      = ST_QUEUED;
    end else begin
      dec_status = ST_FULL;
    end
  end

  // Memory writes come from the clearing pass or from the decision. The
  // sweep never writes, so no read that the sweep uses overlaps a write.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (dec_fire) begin
      mem_we    = dec_we;
      mem_waddr = dec_addr;
      mem_wdata = dec_data;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = addr_r;
    case (state_r)
      S_CLEAR: begin
        addr_nxt = addr_r + AW'(1);
        if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        addr_nxt = '0;
        if (in_fire) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_vld_nxt = 1'b1;
        addr_nxt   = addr_r + AW'(1);
        if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (dec_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        addr_nxt  = '0;
      end
    endcase
  end

  // Request latch and candidate tracking
  always_comb begin
    req_func_nxt   = req_func_r;
    req_pid_nxt    = req_pid_r;
    req_rating_nxt = req_rating_r;
    req_game_nxt   = req_game_r;
    if (in_fire) begin
      req_func_nxt   = in_tuser[0];
      req_pid_nxt    = in_tdata[15:0];
      req_rating_nxt = in_tdata[31:16];
      req_game_nxt   = in_tdata[39:32];
    end

    dup_found_nxt  = in_fire ? 1'b0 : (dup_found_r || dup_hit);
    free_found_nxt = in_fire ? 1'b0 : (free_found_r || free_hit);
    eq_found_nxt   = in_fire ? 1'b0 : (eq_found_r || eq_hit);
    lo_found_nxt   = in_fire ? 1'b0 : (lo_found_r || lo_hit);
    hi_found_nxt   = in_fire ? 1'b0 : (hi_found_r || hi_hit);

    dup_idx_nxt   = dup_hit ? rd_idx_r : dup_idx_r;
    free_idx_nxt  = free_hit ? rd_idx_r : free_idx_r;
    eq_idx_nxt    = eq_hit ? rd_idx_r : eq_idx_r;
    eq_player_nxt = eq_hit ? rd_data.player : eq_player_r;
    lo_idx_nxt    = lo_hit ? rd_idx_r : lo_idx_r;
    lo_rating_nxt = lo_hit ? rd_data.rating : lo_rating_r;
    lo_player_nxt = lo_hit ? rd_data.player : lo_player_r;
    hi_idx_nxt    = hi_hit ? rd_idx_r : hi_idx_r;
    hi_rating_nxt = hi_hit ? rd_data.rating : hi_rating_r;
    hi_player_nxt = hi_hit ? rd_data.player : hi_player_r;
  end

  // Thresholds and output register
  always_comb begin
    lo_thr_nxt = lo_thr_r;
    hi_thr_nxt = hi_thr_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LOWER_THR: lo_thr_nxt = cfg_data;
        CFG_UPPER_THR: hi_thr_nxt = cfg_data;
        default: begin
        end
      endcase
    end

    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_partner_nxt = out_partner_r;
    if (dec_fire) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = dec_status;
      out_partner_nxt = dec_partner;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      addr_r       <= '0;
      rd_vld_r     <= 1'b0;
      dup_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      eq_found_r   <= 1'b0;
      lo_found_r   <= 1'b0;
      hi_found_r   <= 1'b0;
      lo_thr_r     <= THR_RESET;
      hi_thr_r     <= THR_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      rd_vld_r     <= rd_vld_nxt;
      dup_found_r  <= dup_found_nxt;
      free_found_r <= free_found_nxt;
      eq_found_r   <= eq_found_nxt;
      lo_found_r   <= lo_found_nxt;
      hi_found_r   <= hi_found_nxt;
      lo_thr_r     <= lo_thr_nxt;
      hi_thr_r     <= hi_thr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    req_func_r    <= req_func_nxt;
    req_pid_r     <= req_pid_nxt;
    req_rating_r  <= req_rating_nxt;
    req_game_r    <= req_game_nxt;
    dup_idx_r     <= dup_idx_nxt;
    free_idx_r    <= free_idx_nxt;
    eq_idx_r      <= eq_idx_nxt;
    eq_player_r   <= eq_player_nxt;
    lo_idx_r      <= lo_idx_nxt;
    lo_rating_r   <= lo_rating_nxt;
    lo_player_r   <= lo_player_nxt;
    hi_idx_r      <= hi_idx_nxt;
    hi_rating_r   <= hi_rating_nxt;
    hi_player_r   <= hi_player_nxt;
    out_status_r  <= out_status_nxt;
    out_partner_r <= out_partner_nxt;
  end

  // A result is only ever loaded from the decision step.
  `NRPM_ASSERT_IMP(a_result_from_decide, $rose(out_valid_r), $past(state_r == S_DECIDE))
  // The table is never written while it is being swept.
  `NRPM_ASSERT_IMP(a_no_write_in_sweep, (state_r == S_SCAN) || (state_r == S_DRAIN), !mem_we)
  // Read data is only marked valid for addresses issued by the sweep.
  `NRPM_ASSERT_IMP(a_read_from_sweep, rd_vld_r, $past(state_r == S_SCAN))
  // An accepted item always starts a sweep.
  `NRPM_ASSERT_NXT(a_accept_starts_sweep, in_fire, state_r == S_SCAN)

endmodule

`default_nettype wire

// ===== tb/pairing_checker.sv =====
`timescale 1ns / 1ps

module pairing_checker
  import nrpm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [39:0]          in_tdata,   // player_id[15:0], rating[31:16], game_id[39:32]
  input  logic [0:0]           in_tuser,   // func[0]
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [15:0]          out_tdata,  // partner_id[15:0]
  input  logic [2:0]           out_tuser,  // status[2:0]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data,
  output int unsigned          fail_count,
  output int unsigned          pending_count,
  output int unsigned          checked_count
);

  typedef struct packed {
    status_t           status;
    logic [PID_W-1:0]  partner;
  } outcome_t;

  // Shadow copy of the waiting table and of the two gap limits.
  logic                seat_used   [TABLE_DEPTH];
  logic [PID_W-1:0]    seat_pid    [TABLE_DEPTH];
  logic [RATING_W-1:0] seat_rating [TABLE_DEPTH];
  logic [GAME_W-1:0]   seat_game   [TABLE_DEPTH];
  logic [THR_W-1:0]    below_limit;
  logic [THR_W-1:0]    above_limit;

  outcome_t    due_outcomes[$];
  int unsigned mismatches = 0;
  int unsigned checked    = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: pairing mismatch, %s: got %0d, awaited %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Works out the outcome of one request or withdrawal and updates the shadow table.
  task automatic resolve_item(input logic op, input logic [PID_W-1:0] pid,
                              input logic [RATING_W-1:0] rating, input logic [GAME_W-1:0] game,
                              output outcome_t res);
    int held;
    int eq_s;
    int lo_s;
    int hi_s;
    int pick;
    int free_s;
    int dist_lo;
    int dist_hi;
    held    = -1;
    eq_s    = -1;
    lo_s    = -1;
    hi_s    = -1;
    free_s  = -1;
    dist_lo = 0;
    dist_hi = 0;
    res.status  = ST_QUEUED;
    res.partner = '0;

    // A player may wait only once, whatever the game.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (held < 0 && seat_used[i] && seat_pid[i] == pid) held = i;
    end

    if (op == FUNC_WITHDRAW) begin
      if (held >= 0) begin
        seat_used[held] = 1'b0;
        res.status = ST_WITHDRAWN;
      end else begin
        res.status = ST_ABSENT;
      end
    end else if (held >= 0) begin
      res.status = ST_ALREADY;
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (seat_used[i] && seat_game[i] == game) begin
          if (seat_rating[i] == rating) begin
            if (eq_s < 0 || seat_pid[i] < seat_pid[eq_s]) eq_s = i;
          end else if (seat_rating[i] < rating) begin
            if (lo_s < 0 || seat_rating[i] > seat_rating[lo_s] ||
                (seat_rating[i] == seat_rating[lo_s] && seat_pid[i] > seat_pid[lo_s]))
              lo_s = i;
          end else begin
            if (hi_s < 0 || seat_rating[i] < seat_rating[hi_s] ||
                (seat_rating[i] == seat_rating[hi_s] && seat_pid[i] < seat_pid[hi_s]))
              hi_s = i;
          end
        end
      end

      pick = eq_s;
      if (pick < 0) begin
        if (lo_s >= 0) begin
          dist_lo = rating - seat_rating[lo_s];
          if (dist_lo > below_limit) lo_s = -1;
        end
        if (hi_s >= 0) begin
          dist_hi = seat_rating[hi_s] - rating;
          if (dist_hi > above_limit) hi_s = -1;
        end
        // The lower neighbour wins a tie on distance.
        if (lo_s >= 0 && hi_s >= 0) pick = (dist_hi < dist_lo) ? hi_s : lo_s;
        else pick = (lo_s >= 0) ? lo_s : hi_s;
      end

      if (pick >= 0) begin
        seat_used[pick] = 1'b0;
        res.status  = ST_MATCHED;
        res.partner = seat_pid[pick];
      end else begin
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
          if (!seat_used[i]) free_s = i;
        end
        if (free_s < 0) begin
          res.status = ST_FULL;
        end else begin
          seat_used[free_s]   = 1'b1;
          seat_pid[free_s]    = pid;
          seat_rating[free_s] = rating;
          seat_game[free_s]   = game;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    outcome_t got_res;
    outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) seat_used[i] = 1'b0;
      below_limit = THR_RESET;
      above_limit = THR_RESET;
      due_outcomes.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LOWER_THR) below_limit = cfg_data;
        else if (cfg_index == CFG_UPPER_THR) above_limit = cfg_data;
      end
      // Results are taken before new items so that a result can never be
      // matched against an expectation raised at the same edge.
      if (out_tvalid && out_tready) begin
        checked++;
        if (due_outcomes.size() == 0) begin
          report_mismatch("result with nothing awaited, status", out_tuser, 0);
        end else begin
          want = due_outcomes.pop_front();
          if (out_tuser !== want.status)
            report_mismatch("status", out_tuser, want.status);
          if (out_tdata !== want.partner)
            report_mismatch("partner id", out_tdata, want.partner);
        end
      end
      if (in_tvalid && in_tready) begin
        resolve_item(in_tuser[0], in_tdata[15:0], in_tdata[31:16], in_tdata[39:32], got_res);
        due_outcomes.push_back(got_res);
      end
    end
    fail_count    <= mismatches;
    pending_count <= due_outcomes.size();
    checked_count <= checked;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import nrpm_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  // The longest quiet stretch in a correct run is made up of the clearing
  // pass after reset, one sweep of the table, the longest sender gap and a run
  // of receiver stalls. The limit is that taken several times over.
  localparam int unsigned QUIET_LIMIT = 4000;

  // Receiver stall patterns.
  localparam logic [1:0] RX_ALWAYS   = 2'd0;
  localparam logic [1:0] RX_COIN     = 2'd1;
  localparam logic [1:0] RX_SPARSE   = 2'd2;
  localparam logic [1:0] RX_PERIODIC = 2'd3;

  // Every input of the block has a known value from time zero.
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [39:0]          in_tdata   = '0;   // player_id[15:0], rating[31:16], game_id[39:32]
  logic [0:0]           in_tuser   = '0;   // func[0]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;         // partner_id[15:0]
  logic [2:0]           out_tuser;         // status[2:0]
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [THR_W-1:0]     cfg_data   = '0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned checked_count;

  int unsigned requests_sent  = 0;
  int unsigned withdraws_sent = 0;
  int unsigned settings_used  = 1;   // the reset values count as the first setting
  int unsigned burst_left     = 0;
  int unsigned quiet_cycles   = 0;

  logic [1:0]  rx_mode    = RX_ALWAYS;
  int unsigned rx_left    = 0;
  logic [5:0]  rx_phase   = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  nearest_rating_pair_matcher_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The checker watches both channels and the register port on its own, so
  // the stimulus below never needs to know what the block ought to answer.
  pairing_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .checked_count(checked_count)
  );

  // The receiver switches between stall patterns after random stretches, so
  // that back-pressure lands on every point of the block's table sweep and
  // there are also long stretches where results drain freely.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_mode    <= RX_ALWAYS;
      rx_left    <= 300;
      rx_phase   <= '0;
    end else begin
      rx_phase <= rx_phase + 6'd1;
      if (rx_left == 0) begin
        rx_mode <= 2'($urandom_range(0, 3));
        rx_left <= $urandom_range(100, 900);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: begin
          out_tready <= 1'b1;
        end
        RX_COIN: begin
          out_tready <= 1'($urandom_range(0, 1));
        end
        RX_SPARSE: begin
          out_tready <= ($urandom_range(0, 9) == 0);
        end
        default: begin
          // Stalls during one quarter of each pass of the six-bit phase counter.
          out_tready <= (rx_phase[5:4] != 2'b11);
        end
      endcase
    end
  end

  // The watchdog ends a hung run: any transfer on either channel resets it.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results still awaited",
               quiet_cycles, pending_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Presents one item and holds it until the block takes it. The valid is
  // raised again without being lowered when items follow back to back.
  task automatic send_item(input logic op, input logic [PID_W-1:0] pid,
                           input logic [RATING_W-1:0] rating, input logic [GAME_W-1:0] game);
    in_tvalid   <= 1'b1;
    in_tuser[0] <= op;
    in_tdata    <= {game, rating, pid};
    do @(posedge clk); while (!in_tready);
    if (op == FUNC_WITHDRAW) withdraws_sent++;
    else requests_sent++;
  endtask

  // Sends an item, then either carries on with the current burst or starts a
  // new burst, mostly after dropping the valid for a random gap.
  task automatic send_paced(input logic op, input logic [PID_W-1:0] pid,
                            input logic [RATING_W-1:0] rating, input logic [GAME_W-1:0] game);
    int unsigned gap;
    send_item(op, pid, rating, game);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Holds the sender back until every awaited result has come out. The first
  // edge lets the checker register a transfer taken at the current edge.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Writes the lower gap limit and then the upper one; only called with the block idle.
  task automatic set_thresholds(input logic [THR_W-1:0] below, input logic [THR_W-1:0] above);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOWER_THR;
    cfg_data  <= below;
    @(posedge clk);
    cfg_index <= CFG_UPPER_THR;
    cfg_data  <= above;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Directed opening with the reset limits of 100 on either side, starting
  // from an empty table.
  task automatic opening_checks();
    send_paced(FUNC_WITHDRAW, 16'd0,     16'd0,     8'd0);    // nobody waits yet
    send_paced(FUNC_REQUEST,  16'd0,     16'd0,     8'd0);    // lowest values, queued
    send_paced(FUNC_REQUEST,  16'd0,     16'd500,   8'd255);  // same player, other game
    send_paced(FUNC_REQUEST,  16'hFFFF,  16'hFFFF,  8'hFF);   // highest values, queued
    send_paced(FUNC_REQUEST,  16'd1,     16'd65435, 8'hFF);   // upper gap exactly at limit
    send_paced(FUNC_REQUEST,  16'd2,     16'd101,   8'd0);    // lower gap one past limit
    send_paced(FUNC_REQUEST,  16'd3,     16'd50,    8'd0);    // lower neighbour is closer
    send_paced(FUNC_REQUEST,  16'd5,     16'd301,   8'd0);    // too far from everyone
    send_paced(FUNC_REQUEST,  16'd6,     16'd201,   8'd0);    // equal distance, lower wins
    send_paced(FUNC_REQUEST,  16'd7,     16'd301,   8'd1);    // another game's pool
    send_paced(FUNC_WITHDRAW, 16'd7,     16'd0,     8'd0);
    send_paced(FUNC_WITHDRAW, 16'd7,     16'd0,     8'd0);    // already gone
    send_paced(FUNC_REQUEST,  16'd8,     16'd400,   8'd0);    // only a lower one remains
    send_paced(FUNC_REQUEST,  16'd9,     16'd1000,  8'd3);
    send_paced(FUNC_REQUEST,  16'd10,    16'd1000,  8'd3);    // exact rating match
    send_paced(FUNC_REQUEST,  16'hAAAA,  16'h5555,  8'hAA);
    send_paced(FUNC_REQUEST,  16'h5555,  16'hAAAA,  8'h55);
    send_paced(FUNC_WITHDRAW, 16'hAAAA,  16'hFFFF,  8'hFF);   // ignored fields all ones
    send_paced(FUNC_WITHDRAW, 16'h5555,  16'h0000,  8'h00);
    send_paced(FUNC_REQUEST,  16'h8000,  16'd0,     8'h80);
    send_paced(FUNC_REQUEST,  16'h7FFF,  16'hFFFF,  8'h80);   // widest gap, stays queued
  endtask

  // One random phase: a fresh pair of limits and a population of players,
  // games and ratings chosen to push the table towards matching or filling.
  task automatic run_phase(input int unsigned below, input int unsigned above,
                           input int unsigned pool, input int unsigned games,
                           input int unsigned r_lo, input int unsigned r_hi,
                           input int unsigned count);
    logic                op;
    logic [PID_W-1:0]    pid;
    logic [RATING_W-1:0] rating;
    logic [GAME_W-1:0]   game;
    int unsigned         sel;
    wait_drained();
    set_thresholds(THR_W'(below), THR_W'(above));
    for (int n = 0; n < count; n++) begin
      // Players come mostly from a small pool, so repeats and withdrawals of
      // waiting players are common; a few ids are drawn from the whole range.
      op  = ($urandom_range(0, 99) < 25) ? FUNC_WITHDRAW : FUNC_REQUEST;
      pid = ($urandom_range(0, 9) == 0) ? PID_W'($urandom) : PID_W'($urandom_range(0, pool - 1));
      sel = $urandom_range(0, 19);
      if (sel == 0) rating = '0;
      else if (sel == 1) rating = '1;
      else if (sel < 4) rating = RATING_W'($urandom);
      else rating = RATING_W'($urandom_range(r_lo, r_hi));
      game = ($urandom_range(0, 15) == 0) ? GAME_W'($urandom)
                                          : GAME_W'($urandom_range(0, games - 1));
      send_paced(op, pid, rating, game);
      // Now and then the sender waits for the block to empty completely.
      if ($urandom_range(0, 119) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // The block is busy clearing its table after reset; the first transfer
    // simply waits for in_tready.
    opening_checks();

    // Zero limits with ratings spread wide: hardly anything matches, so the
    // table fills and the full case comes up again and again.
    run_phase(0, 0, 200, 4, 0, 65535, 200);
    // Largest limits: any waiting entry of the same game is close enough.
    run_phase(65535, 65535, 96, 3, 0, 65535, 200);
    run_phase(0, 65535, 96, 3, 0, 65535, 200);
    run_phase(65535, 0, 96, 3, 0, 65535, 200);
    // Reset limits with ratings clustered so that gaps near the limit are common.
    run_phase(100, 100, 64, 2, 1000, 1400, 200);
    run_phase($urandom_range(0, 300), $urandom_range(0, 300), 80, 3, 2000, 2600, 200);
    run_phase($urandom_range(0, 65535), $urandom_range(0, 65535), 120, 5, 0, 65535, 200);

    wait_drained();
    // Nothing else should appear; give the block a full sweep to prove it.
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("covered: %0d requests and %0d withdrawals under %0d pairs of gap limits",
             requests_sent, withdraws_sent, settings_used);
    $display("covered: %0d results checked, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
